// ----- rtl/utqd_pkg.sv -----
package utqd_pkg;

    // Part codes, also used as section codes
    localparam logic [1:0] PART_PATH  = 2'd0;
    localparam logic [1:0] PART_KEY   = 2'd1;
    localparam logic [1:0] PART_VALUE = 2'd2;

    // Escape progress codes
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_ONE  = 2'd1;
    localparam logic [1:0] ESC_TWO  = 2'd2;

    // Characters with a meaning in the target
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Most results one input word can cause
    localparam int RES_MAX = 4;
    localparam int RES_CW  = $clog2(RES_MAX + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] part;
        logic       part_end;
    } t_res;

    typedef struct packed {
        logic [1:0] section;
        logic [1:0] escape_count;
        logic [7:0] escape_digit;
        logic       pair_open;
    } t_state;

    // Hex digit: bit 4 says valid, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- rtl/url_target_query_decoder.sv -----
// Request-target decoder.
// Input stream: one raw byte of the target per word in s_axis_tdata; a word
// with s_axis_tlast high marks the end of the target (its byte is ignored)
// and flushes a pending escape and closes the open part.
// Output stream: decoded bytes and part-closing markers; m_axis_tuser tags
// each word with byte_valid, part (path, key, value) and part_end, and
// m_axis_tlast marks the last word caused by one input word.
// One input word yields zero to four output words.
// A word is taken into the input register and its results are shown from the
// result register.
// Throughput: one input word per cycle while each yields at most one result and
// the receiver is ready; a word that yields several holds the input until the
// result register, which drains one word per cycle while ready, has drained it.
// A stalled receiver holds the current output word; one further input word
// waits in the input register, then s_axis_tready drops.
// Reset clears both stages and returns the parser to the path section.
module url_target_query_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_flag
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [0] byte_valid, [2:1] part, [3] part_end
    output logic       m_axis_tlast    // last_of_run
);

    logic                                   r_in_valid;
    logic [7:0]                             r_in_byte;
    logic                                   r_in_end;
    logic                                   buf_free;
    logic                                   load;
    utqd_pkg::t_res [utqd_pkg::RES_MAX-1:0] dec_res;
    logic [utqd_pkg::RES_CW-1:0]            dec_num;
    utqd_pkg::t_res                         out_res;

    assign load          = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || buf_free;

    // Hold the accepted word until the result register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    utqd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_in_byte  (r_in_byte),
        .i_end_flag (r_in_end),
        .o_res      (dec_res),
        .o_num      (dec_num)
    );

    utqd_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_res    (dec_res),
        .i_num    (dec_num),
        .o_free   (buf_free),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_res    (out_res),
        .o_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = {out_res.part_end, out_res.part, out_res.byte_valid};

endmodule

// ----- rtl/utqd_decode.sv -----
module utqd_decode (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic [7:0]                              i_in_byte,
    input  logic                                    i_end_flag,
    output utqd_pkg::t_res [utqd_pkg::RES_MAX-1:0]  o_res,
    output logic [utqd_pkg::RES_CW-1:0]             o_num
);

    utqd_pkg::t_state r_st;
    utqd_pkg::t_state n_st;

    // Work out the results of one word and the state it leaves
    always_comb begin
        logic [7:0]                        c;
        logic [1:0]                        sec;
        logic [utqd_pkg::RES_CW-1:0]       n;
        logic                              do_flush;
        logic                              do_plain;
        logic [4:0]                        lo;
        logic [4:0]                        hi;
        utqd_pkg::t_res [utqd_pkg::RES_MAX-1:0] res;

        c        = i_in_byte;
        sec      = r_st.section;
        n_st     = r_st;
        n        = '0;
        res      = '0;
        do_plain = 1'b0;
        lo       = utqd_pkg::hex_value(c);
        hi       = utqd_pkg::hex_value(r_st.escape_digit);

        // Separators and the end word flush a pending escape
        do_flush = i_end_flag
            || (sec == utqd_pkg::PART_PATH && c == utqd_pkg::CH_QMARK)
            || (sec == utqd_pkg::PART_KEY && (c == utqd_pkg::CH_AMP || c == utqd_pkg::CH_EQ))
            || (sec != utqd_pkg::PART_PATH && sec != utqd_pkg::PART_KEY
                && c == utqd_pkg::CH_AMP);

        if (do_flush) begin
            if (r_st.escape_count != utqd_pkg::ESC_NONE) begin
                res[n[1:0]] = '{utqd_pkg::CH_PCT, 1'b1, sec, 1'b0};
                n = n + 1'b1;
            end
            if (r_st.escape_count != utqd_pkg::ESC_NONE
                    && r_st.escape_count != utqd_pkg::ESC_ONE) begin
                res[n[1:0]] = '{r_st.escape_digit, 1'b1, sec, 1'b0};
                n = n + 1'b1;
            end
            n_st.escape_count = utqd_pkg::ESC_NONE;
        end else begin
            // Ordinary byte: advance the escape or pass it on
            unique case (r_st.escape_count)
                utqd_pkg::ESC_NONE: begin
                    do_plain = 1'b1;
                end
                utqd_pkg::ESC_ONE: begin
                    if (lo[4]) begin
                        n_st.escape_digit = c;
                        n_st.escape_count = utqd_pkg::ESC_TWO;
                    end else begin
                        res[n[1:0]] = '{utqd_pkg::CH_PCT, 1'b1, sec, 1'b0};
                        n = n + 1'b1;
                        n_st.escape_count = utqd_pkg::ESC_NONE;
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    n_st.escape_count = utqd_pkg::ESC_NONE;
                    if (lo[4] && hi[4]) begin
                        res[n[1:0]] = '{{hi[3:0], lo[3:0]}, 1'b1, sec, 1'b0};
                        n = n + 1'b1;
                    end else begin
                        res[n[1:0]] = '{utqd_pkg::CH_PCT, 1'b1, sec, 1'b0};
                        n = n + 1'b1;
                        res[n[1:0]] = '{r_st.escape_digit, 1'b1, sec, 1'b0};
                        n = n + 1'b1;
                        do_plain = 1'b1;
                    end
                end
            endcase
            if (do_plain) begin
                if (c == utqd_pkg::CH_PCT) begin
                    n_st.escape_count = utqd_pkg::ESC_ONE;
                end else begin
                    res[n[1:0]] = '{(c == utqd_pkg::CH_PLUS) ? utqd_pkg::CH_SPACE : c,
                                    1'b1, sec, 1'b0};
                    n = n + 1'b1;
                end
            end
            if (sec == utqd_pkg::PART_KEY) begin
                n_st.pair_open = 1'b1;
            end
        end

        // Close parts and move between sections
        if (do_flush) begin
            unique case (sec)
                utqd_pkg::PART_PATH: begin
                    res[n[1:0]] = '{8'd0, 1'b0, utqd_pkg::PART_PATH, 1'b1};
                    n = n + 1'b1;
                    n_st.section = utqd_pkg::PART_KEY;
                end
                utqd_pkg::PART_KEY: begin
                    if (r_st.pair_open || (!i_end_flag && c == utqd_pkg::CH_EQ)) begin
                        res[n[1:0]] = '{8'd0, 1'b0, utqd_pkg::PART_KEY, 1'b1};
                        n = n + 1'b1;
                    end
                    if (!i_end_flag && c == utqd_pkg::CH_EQ) begin
                        n_st.section = utqd_pkg::PART_VALUE;
                    end else if (r_st.pair_open) begin
                        res[n[1:0]] = '{8'd0, 1'b0, utqd_pkg::PART_VALUE, 1'b1};
                        n = n + 1'b1;
                    end
                end
                default: begin
                    res[n[1:0]] = '{8'd0, 1'b0, utqd_pkg::PART_VALUE, 1'b1};
                    n = n + 1'b1;
                    n_st.section = utqd_pkg::PART_KEY;
                end
            endcase
            n_st.pair_open = 1'b0;
            if (i_end_flag) begin
                n_st = '0;
            end
        end

        o_res = res;
        o_num = n;
    end

    // Hold the parser state, advance it on each loaded word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_load) begin
            r_st <= n_st;
        end
    end

endmodule

// ----- rtl/utqd_outbuf.sv -----
module utqd_outbuf (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  utqd_pkg::t_res [utqd_pkg::RES_MAX-1:0]  i_res,
    input  logic [utqd_pkg::RES_CW-1:0]             i_num,
    output logic                                    o_free,
    input  logic                                    i_tready,
    output logic                                    o_tvalid,
    output utqd_pkg::t_res                          o_res,
    output logic                                    o_tlast
);

    localparam logic [utqd_pkg::RES_CW-1:0] RES_ONE = {{(utqd_pkg::RES_CW-1){1'b0}}, 1'b1};

    utqd_pkg::t_res [utqd_pkg::RES_MAX-1:0] r_res;
    logic [utqd_pkg::RES_CW-1:0]            r_left;
    logic [1:0]                             r_sel;
    logic                                   out_acc;

    assign o_tvalid = (r_left != '0);
    assign out_acc  = o_tvalid && i_tready;
    // Free when empty or once the last pending word leaves in this cycle
    assign o_free   = (r_left == '0) || (r_left == RES_ONE && i_tready);
    assign o_res    = r_res[r_sel];
    assign o_tlast  = (r_left == RES_ONE);

    // Hold results and step through them one word at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_sel  <= '0;
        end else if (i_load) begin
            r_left <= i_num;
            r_sel  <= '0;
        end else if (out_acc) begin
            r_left <= r_left - RES_ONE;
            r_sel  <= r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- rtl/utqd_checker.sv -----
module utqd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Hold a waiting input word unchanged until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("input word changed while waiting");

    // Hold a stalled output word unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Marker words carry no byte and always close a part
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == !m_axis_tuser[3])
            && (m_axis_tuser[0] || m_axis_tdata == 8'd0))
        else $error("malformed marker or byte word");

    // Part code is path, key or value
    a_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
        else $error("unused part code on output");

    // Nothing is shown straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind url_target_query_decoder utqd_checker u_utqd_checker (.*);

// ----- tb/tb_url_target_query_decoder.sv -----
module tb_url_target_query_decoder;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 75;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
    } t_target_word;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic [1:0] part;
        logic       part_end;
        logic       last;
    } t_decoded_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;   // end_flag
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte
    logic [3:0] m_axis_tuser;          // [0] byte_valid, [2:1] part, [3] part_end
    logic       m_axis_tlast;          // last_of_run

    // Raw target words still to send, decoded words still to arrive
    t_target_word  target_q[$];
    t_decoded_word decoded_q[$];
    t_decoded_word run_q[$];

    // Parser state of the predictor
    logic [1:0] sect;
    logic [1:0] esc_cnt;
    logic [7:0] esc_first;
    logic       pair_open;

    int mismatches = 0;
    int idle_cycles = 0;
    int words_made = 0;
    bit word_taken = 1'b0;

    int gap_left = 0;
    int burst_left = 1;
    int stall_left = 0;
    int calm_left = 0;

    url_target_query_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Decoding predictor
    // ---------------------------------------------------------------

    // Bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] v;
        lc = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (lc >= 8'h61 && lc <= 8'h66) begin
            v = lc - 8'h57;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    task automatic emit_word(input logic [7:0] b, input logic v, input logic [1:0] p,
                             input logic pe);
        t_decoded_word w;
        w.data       = b;
        w.byte_valid = v;
        w.part       = p;
        w.part_end   = pe;
        w.last       = 1'b0;
        if (run_q.size() < utqd_pkg::RES_MAX) run_q.push_back(w);
    endtask

    task automatic emit_char(input logic [7:0] b);
        emit_word(b, 1'b1, sect, 1'b0);
    endtask

    task automatic close_part(input logic [1:0] p);
        emit_word(8'h00, 1'b0, p, 1'b1);
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == utqd_pkg::CH_PCT) esc_cnt = utqd_pkg::ESC_ONE;
        else if (c == utqd_pkg::CH_PLUS) emit_char(utqd_pkg::CH_SPACE);
        else emit_char(c);
    endtask

    task automatic take_escaped(input logic [7:0] c);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = hex_digit(c);
        hi = hex_digit(esc_first);
        if (esc_cnt == utqd_pkg::ESC_NONE) begin
            take_plain(c);
        end else if (esc_cnt == utqd_pkg::ESC_ONE) begin
            if (lo[4]) begin
                esc_first = c;
                esc_cnt = utqd_pkg::ESC_TWO;
            end else begin
                // bad first digit: literal percent, then reprocess the byte
                emit_char(utqd_pkg::CH_PCT);
                esc_cnt = utqd_pkg::ESC_NONE;
                take_plain(c);
            end
        end else begin
            esc_cnt = utqd_pkg::ESC_NONE;
            if (lo[4] && hi[4]) begin
                emit_char({hi[3:0], lo[3:0]});
            end else begin
                emit_char(utqd_pkg::CH_PCT);
                emit_char(esc_first);
                take_plain(c);
            end
        end
    endtask

    // Emit a pending escape literally
    task automatic flush_escape();
        if (esc_cnt == utqd_pkg::ESC_ONE) begin
            emit_char(utqd_pkg::CH_PCT);
        end else if (esc_cnt != utqd_pkg::ESC_NONE) begin
            emit_char(utqd_pkg::CH_PCT);
            emit_char(esc_first);
        end
        esc_cnt = utqd_pkg::ESC_NONE;
    endtask

    task automatic restart_parser();
        sect = utqd_pkg::PART_PATH;
        esc_cnt = utqd_pkg::ESC_NONE;
        esc_first = 8'h00;
        pair_open = 1'b0;
    endtask

    task automatic decode_input(input t_target_word w);
        t_decoded_word r;
        run_q.delete();
        if (w.is_end) begin
            flush_escape();
            if (sect == utqd_pkg::PART_PATH) begin
                close_part(utqd_pkg::PART_PATH);
            end else if (sect == utqd_pkg::PART_KEY) begin
                if (pair_open) begin
                    close_part(utqd_pkg::PART_KEY);
                    close_part(utqd_pkg::PART_VALUE);
                end
            end else begin
                close_part(utqd_pkg::PART_VALUE);
            end
            restart_parser();
        end else if (sect == utqd_pkg::PART_PATH) begin
            if (w.data == utqd_pkg::CH_QMARK) begin
                flush_escape();
                close_part(utqd_pkg::PART_PATH);
                sect = utqd_pkg::PART_KEY;
                pair_open = 1'b0;
            end else begin
                take_escaped(w.data);
            end
        end else if (sect == utqd_pkg::PART_KEY) begin
            if (w.data == utqd_pkg::CH_AMP) begin
                flush_escape();
                if (pair_open) begin
                    close_part(utqd_pkg::PART_KEY);
                    close_part(utqd_pkg::PART_VALUE);
                end
                pair_open = 1'b0;
            end else if (w.data == utqd_pkg::CH_EQ) begin
                flush_escape();
                close_part(utqd_pkg::PART_KEY);
                sect = utqd_pkg::PART_VALUE;
                pair_open = 1'b0;
            end else begin
                pair_open = 1'b1;
                take_escaped(w.data);
            end
        end else begin
            if (w.data == utqd_pkg::CH_AMP) begin
                flush_escape();
                close_part(utqd_pkg::PART_VALUE);
                sect = utqd_pkg::PART_KEY;
                pair_open = 1'b0;
            end else begin
                take_escaped(w.data);
            end
        end
        // mark the final word of this run and queue the lot
        for (int i = 0; i < run_q.size(); i++) begin
            r = run_q[i];
            r.last = (i == run_q.size() - 1);
            decoded_q.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        t_target_word w;
        w.data = b;
        w.is_end = 1'b0;
        target_q.push_back(w);
        words_made++;
    endtask

    task automatic push_end();
        t_target_word w;
        w.data = 8'($urandom_range(0, 255));
        w.is_end = 1'b1;
        target_q.push_back(w);
        words_made++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10) return 8'(8'h30 + n);
        return 8'((($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + n - 10);
    endfunction

    // Short run of letters, digits, plus signs, escapes good and bad, odd bytes
    task automatic rand_piece();
        int n;
        int kind;
        n = $urandom_range(0, 4);
        repeat (n) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                push_byte(8'(8'h61 + $urandom_range(0, 25)));
            end else if (kind < 5) begin
                push_byte(8'(8'h30 + $urandom_range(0, 9)));
            end else if (kind == 5) begin
                push_byte(utqd_pkg::CH_PLUS);
            end else if (kind < 8) begin
                push_byte(utqd_pkg::CH_PCT);
                push_byte(hex_char());
                push_byte(hex_char());
            end else if (kind == 8) begin
                push_byte(utqd_pkg::CH_PCT);
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Well-formed target: path, optional query of pairs, end word
    task automatic gen_target();
        int pairs;
        rand_piece();
        if ($urandom_range(0, 4) != 0) begin
            push_byte(utqd_pkg::CH_QMARK);
            pairs = $urandom_range(0, 3);
            for (int i = 0; i < pairs; i++) begin
                if (i > 0) push_byte(utqd_pkg::CH_AMP);
                if ($urandom_range(0, 5) != 0) begin
                    rand_piece();
                    if ($urandom_range(0, 3) != 0) begin
                        push_byte(utqd_pkg::CH_EQ);
                        rand_piece();
                    end
                end
            end
            if ($urandom_range(0, 3) == 0) push_byte(utqd_pkg::CH_AMP);
        end
        push_end();
    endtask

    // Raw noise, with the odd stray end word
    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) push_end();
            else push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of words with random gaps, hold until taken
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && !word_taken)) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left--;
            end else if (target_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= target_q[0].data;
                s_axis_tlast <= target_q[0].is_end;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: short stalls, with calm stretches of steady ready
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (calm_left > 0) begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3) stall_left = $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(10, 40);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted input, check accepted output
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_decoded_word got;
        t_decoded_word want;
        if (i_rst_n) begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) decode_input(target_q.pop_front());
            if (m_axis_tvalid && m_axis_tready) begin
                got.data       = m_axis_tdata;
                got.byte_valid = m_axis_tuser[0];
                got.part       = m_axis_tuser[2:1];
                got.part_end   = m_axis_tuser[3];
                got.last       = m_axis_tlast;
                if (decoded_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected word: data=%h valid=%b part=%0d end=%b last=%b",
                                 got.data, got.byte_valid, got.part, got.part_end, got.last);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
                        got.part !== want.part || got.part_end !== want.part_end ||
                        got.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("mismatch: exp data=%h valid=%b part=%0d end=%b last=%b",
                                     want.data, want.byte_valid, want.part, want.part_end,
                                     want.last);
                            $display("          got data=%h valid=%b part=%0d end=%b last=%b",
                                     got.data, got.byte_valid, got.part, got.part_end,
                                     got.last);
                        end
                        mismatches++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: give up once nothing has moved for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int start;
        restart_parser();

        // Directed: byte extremes, escapes cut short or bad, empty pairs,
        // key without value, empty key, escape at a separator, empty path
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("%4+%%G?&&k&=v%4");
        push_end();
        push_end();
        push_text("?k%A&x");
        push_end();

        // Random: mostly well-formed targets, some raw noise
        start = words_made;
        while (words_made - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) gen_noise();
            else gen_target();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (target_q.size() != 0 || decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
